// ===== rtl/prhc_pkg.sv =====
// Shared types, constants and a helper function of the preset rotator homing controller.
package prhc_pkg;

   localparam int ANGLE_W     = 9;
   localparam int STEP_W      = 15;
   localparam int SPD_W       = 22;
   localparam int MOVE_W      = 12;
   localparam int HELD_W      = 12;
   localparam int IDX_W       = 2;
   localparam int COUNT_W     = 3;
   localparam int NUM_PRESETS = 4;
   localparam int MAG_W       = 8;
   localparam int PROD_W      = MAG_W + SPD_W;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 22;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int DEBOUNCE_TICKS_DEF   = 50;
   localparam int LONG_PRESS_TICKS_DEF = 3000;
   localparam int MAX_PRESETS_DEF      = 4;

   localparam logic [HELD_W-1:0]        HELD_MAX    = '1;
   localparam logic signed [STEP_W-1:0] CRAWL_STEPS = -15'sd10;
   localparam logic signed [10:0]       HALF_TURN   = 11'sd180;
   localparam logic signed [10:0]       FULL_TURN   = 11'sd360;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_ANGLE_0 = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_ANGLE_1 = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_ANGLE_2 = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_ANGLE_3 = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESET_COUNT   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_DEG  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEPS  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_OFFSET    = 4'd7;

   localparam logic [ANGLE_W-1:0] PRESET_ANGLE_0_RST = 9'h1E2;
   localparam logic [ANGLE_W-1:0] PRESET_ANGLE_1_RST = 9'd0;
   localparam logic [ANGLE_W-1:0] PRESET_ANGLE_2_RST = 9'd30;
   localparam logic [ANGLE_W-1:0] PRESET_ANGLE_3_RST = 9'd0;
   localparam logic [COUNT_W-1:0] PRESET_COUNT_RST   = 3'd3;
   localparam logic [SPD_W-1:0]   STEPS_PER_DEG_RST  = 22'd370585;
   localparam logic [MOVE_W-1:0]  RELEASE_STEPS_RST  = 12'd11;
   localparam logic [MOVE_W-1:0]  ZERO_OFFSET_RST    = 12'd28;

   typedef struct packed {
      logic button_level;
      logic limit_level;
   } req_type;

   typedef struct packed {
      logic signed [STEP_W-1:0] step_count;
      logic                     led_on;
      logic [IDX_W-1:0]         preset_index;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [NUM_PRESETS-1:0][ANGLE_W-1:0] preset_angle;
      logic [COUNT_W-1:0]                  preset_count;
      logic [SPD_W-1:0]                    steps_per_degree_q16;
      logic [MOVE_W-1:0]                   release_steps;
      logic [MOVE_W-1:0]                   zero_offset_steps;
   } cfg_type;

   typedef struct packed {
      logic                       homing_active;
      logic                       previous_button;
      logic [HELD_W-1:0]          held_ticks;
      logic                       long_press_active;
      logic                       short_press_latched;
      logic [IDX_W-1:0]           current_index;
      logic signed [ANGLE_W-1:0]  current_angle;
   } state_type;

   function automatic logic [IDX_W-1:0] next_index(
      input logic [IDX_W-1:0]   idx,
      input logic [COUNT_W-1:0] count,
      input logic [COUNT_W-1:0] max_count
   );
      logic [COUNT_W-1:0] cnt;
      logic [COUNT_W-1:0] a;
      cnt = count;
      if (cnt == '0) begin
         cnt = COUNT_W'(1);
      end
      if (cnt > max_count) begin
         cnt = max_count;
      end
      a = COUNT_W'(idx) + COUNT_W'(1);
      for (int k = 0; k < NUM_PRESETS; k++) begin
         if (a >= cnt) begin
            a = a - cnt;
         end
      end
      return a[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/prhc_csr_regs.sv =====
// Configuration registers of the preset rotator homing controller.
module prhc_csr_regs
   import prhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESET_ANGLE_0: cfg_in.preset_angle[0] = csr_wdata[ANGLE_W-1:0];
            CSR_PRESET_ANGLE_1: cfg_in.preset_angle[1] = csr_wdata[ANGLE_W-1:0];
            CSR_PRESET_ANGLE_2: cfg_in.preset_angle[2] = csr_wdata[ANGLE_W-1:0];
            CSR_PRESET_ANGLE_3: cfg_in.preset_angle[3] = csr_wdata[ANGLE_W-1:0];
            CSR_PRESET_COUNT:   cfg_in.preset_count = csr_wdata[COUNT_W-1:0];
            CSR_STEPS_PER_DEG:  cfg_in.steps_per_degree_q16 = csr_wdata[SPD_W-1:0];
            CSR_RELEASE_STEPS:  cfg_in.release_steps = csr_wdata[MOVE_W-1:0];
            CSR_ZERO_OFFSET:    cfg_in.zero_offset_steps = csr_wdata[MOVE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preset_angle[0]      <= PRESET_ANGLE_0_RST;
         cfg_ff.preset_angle[1]      <= PRESET_ANGLE_1_RST;
         cfg_ff.preset_angle[2]      <= PRESET_ANGLE_2_RST;
         cfg_ff.preset_angle[3]      <= PRESET_ANGLE_3_RST;
         cfg_ff.preset_count         <= PRESET_COUNT_RST;
         cfg_ff.steps_per_degree_q16 <= STEPS_PER_DEG_RST;
         cfg_ff.release_steps        <= RELEASE_STEPS_RST;
         cfg_ff.zero_offset_steps    <= ZERO_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/prhc_step.sv =====
// Per-tick control state and result generation of the preset rotator homing controller.
module prhc_step
   import prhc_pkg::*;
#(
   parameter int DEBOUNCE_TICKS   = DEBOUNCE_TICKS_DEF,
   parameter int LONG_PRESS_TICKS = LONG_PRESS_TICKS_DEF,
   parameter int MAX_PRESETS      = MAX_PRESETS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   input  cfg_type cfg,
   output logic    push_one,
   output logic    push_two,
   output rsp_type rsp_first,
   output rsp_type rsp_second
);

   state_type st_ff;
   state_type st_in;

   logic                      btn;
   logic                      lim;
   logic                      do_home;
   logic [IDX_W-1:0]          nxt;
   logic signed [ANGLE_W-1:0] target;
   logic signed [10:0]        diff;
   logic signed [10:0]        mag_w;
   logic [MAG_W-1:0]          mag;
   logic                      neg;
   logic [PROD_W-1:0]         prod;
   logic [STEP_W-2:0]         whole;
   logic signed [STEP_W-1:0]  steps;
   rsp_type                   r0;
   rsp_type                   r1;
   logic                      two;

   always_comb begin
      btn     = req.button_level;
      lim     = req.limit_level;
      st_in   = st_ff;
      do_home = 1'b0;
      two     = 1'b0;
      r0      = '0;
      r1      = '0;
      r0.led_on = lim;
      r1.led_on = lim;
      r0.last   = 1'b1;
      r1.last   = 1'b1;
      nxt     = '0;
      target  = '0;
      diff    = '0;
      mag_w   = '0;
      mag     = '0;
      neg     = 1'b0;
      prod    = '0;
      whole   = '0;
      steps   = '0;

      if (st_ff.homing_active) begin
         if (st_ff.held_ticks != HELD_MAX) begin
            st_in.held_ticks = st_ff.held_ticks + HELD_W'(1);
         end
         do_home = 1'b1;
      end else begin
         if (btn != st_ff.previous_button) begin
            st_in.previous_button = btn;
            st_in.held_ticks      = '0;
         end else if (st_ff.held_ticks != HELD_MAX) begin
            st_in.held_ticks = st_ff.held_ticks + HELD_W'(1);
         end

         if (!btn && st_in.held_ticks >= HELD_W'(LONG_PRESS_TICKS)
             && !st_ff.long_press_active) begin
            st_in.long_press_active = 1'b1;
            st_in.current_angle     = $signed(cfg.preset_angle[0]);
            st_in.current_index     = '0;
         end
         if (btn && st_ff.long_press_active) begin
            st_in.long_press_active = 1'b0;
         end

         if (st_in.long_press_active && !lim) begin
            r0.step_count = CRAWL_STEPS;
         end else if (!btn && st_in.held_ticks > HELD_W'(DEBOUNCE_TICKS)
                      && !st_ff.short_press_latched) begin
            st_in.short_press_latched = 1'b1;
            nxt = next_index(st_in.current_index, cfg.preset_count,
                             COUNT_W'(MAX_PRESETS));
            if (nxt == '0) begin
               st_in.homing_active = 1'b1;
               do_home             = 1'b1;
            end else begin
               target = $signed(cfg.preset_angle[nxt]);
               diff   = 11'(target) - 11'(st_in.current_angle);
               if (diff > HALF_TURN) begin
                  diff = diff - FULL_TURN;
               end
               if (diff < -HALF_TURN) begin
                  diff = diff + FULL_TURN;
               end
               neg   = diff[10];
               mag_w = neg ? -diff : diff;
               mag   = mag_w[MAG_W-1:0];
               prod  = PROD_W'(mag) * PROD_W'(cfg.steps_per_degree_q16);
               whole = prod[PROD_W-1:16];
               steps = neg ? -$signed({1'b0, whole}) : $signed({1'b0, whole});
               r0.step_count       = steps;
               st_in.current_angle = target;
               st_in.current_index = nxt;
            end
         end else begin
            if (btn) begin
               st_in.short_press_latched = 1'b0;
            end
         end
      end

      r0.preset_index = st_in.current_index;

      if (do_home) begin
         if (!lim) begin
            r0.step_count = CRAWL_STEPS;
         end else begin
            r0.step_count       = $signed(STEP_W'(cfg.release_steps));
            r0.last             = 1'b0;
            st_in.current_angle = $signed(cfg.preset_angle[0]);
            st_in.current_index = '0;
            st_in.homing_active = 1'b0;
            r1.step_count       = $signed(STEP_W'(cfg.zero_offset_steps));
            r1.preset_index     = '0;
            two                 = 1'b1;
         end
      end
   end

   assign push_one   = fire;
   assign push_two   = fire && two;
   assign rsp_first  = r0;
   assign rsp_second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.homing_active       <= 1'b1;
         st_ff.previous_button     <= 1'b1;
         st_ff.held_ticks          <= '0;
         st_ff.long_press_active   <= 1'b0;
         st_ff.short_press_latched <= 1'b0;
         st_ff.current_index       <= '0;
         st_ff.current_angle       <= $signed(PRESET_ANGLE_0_RST);
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/prhc_rsp_queue.sv =====
// Result queue that takes one or two items per cycle and hands out one per cycle while rsp_ready is high.
module prhc_rsp_queue
   import prhc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_one,
   input  logic              push_two,
   input  rsp_type           push_first,
   input  rsp_type           push_second,
   output logic [QCNT_W-1:0] fill,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;
   logic [QCNT_W-1:0]   pushed;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      pushed    = push_two ? QCNT_W'(2) : (push_one ? QCNT_W'(1) : '0);
      wr_ptr_in = wr_ptr_ff + QPTR_W'(pushed);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + pushed - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_one) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_two) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/preset_rotator_homing_controller.sv =====
// Top level of the preset rotator homing controller.
//
// One request item per 1 ms tick carries the button level and the limit switch
// level; the block answers with one or two response items of signed step
// commands, the LED state, the preset index and a last flag on the final one.
// The csr channel writes the eight configuration registers (index 0..7, higher
// indexes are ignored); it is always ready. The user must write it only while
// the block idles; the block itself does not enforce this. A request item is
// taken into an input register, processed once at most two queue entries are
// filled (one 8x22 multiply for a preset move) and written into a four-entry
// response queue. Throughput is one request item per cycle while the queue has
// room; a tick that releases the homing switch gives two response items.
// When the receiver stalls, the queue fills and req_ready drops once fewer than
// two entries are free; nothing is lost or repeated.
// Reset loads the register reset values, empties the queue and starts homing.
module preset_rotator_homing_controller
   import prhc_pkg::*;
#(
   parameter int DEBOUNCE_TICKS   = DEBOUNCE_TICKS_DEF,
   parameter int LONG_PRESS_TICKS = LONG_PRESS_TICKS_DEF,
   parameter int MAX_PRESETS      = MAX_PRESETS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type           cfg;
   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_data_ff;
   logic              fire;
   logic              push_one;
   logic              push_two;
   rsp_type           rsp_first;
   rsp_type           rsp_second;
   logic [QCNT_W-1:0] fill;

   assign fire        = in_valid_ff && (fill <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   prhc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prhc_step #(
      .DEBOUNCE_TICKS   (DEBOUNCE_TICKS),
      .LONG_PRESS_TICKS (LONG_PRESS_TICKS),
      .MAX_PRESETS      (MAX_PRESETS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .req        (in_data_ff),
      .cfg        (cfg),
      .push_one   (push_one),
      .push_two   (push_two),
      .rsp_first  (rsp_first),
      .rsp_second (rsp_second)
   );

   prhc_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_one    (push_one),
      .push_two    (push_two),
      .push_first  (rsp_first),
      .push_second (rsp_second),
      .fill        (fill),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/rotator_checker.sv =====
// Checker for the preset rotator: predicts each tick's step command items and compares them.
`timescale 1ns / 1ps
module rotator_checker
   import prhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     cmds_owed,
   output int                     fault_count
);

   localparam int STEP_HI = (1 << (STEP_W - 1)) - 1;
   localparam int STEP_LO = -(1 << (STEP_W - 1));

   logic signed [ANGLE_W-1:0] preset_deg [NUM_PRESETS];
   logic [COUNT_W-1:0]        presets_used;
   logic [SPD_W-1:0]          steps_per_deg;
   logic [MOVE_W-1:0]         backoff_steps;
   logic [MOVE_W-1:0]         offset_steps;

   logic                      homing;
   logic                      button_seen;
   logic [HELD_W-1:0]         held_for;
   logic                      long_hold;
   logic                      press_taken;
   logic [IDX_W-1:0]          at_index;
   logic signed [ANGLE_W-1:0] at_angle;

   rsp_type cmds_due [$];
   int      faults;

   function automatic logic signed [STEP_W-1:0] steps_for(input int delta);
      longint unsigned whole;
      whole = (longint'(delta < 0 ? -delta : delta) * longint'(steps_per_deg)) >> 16;
      if (delta < 0) begin
         if (whole > longint'(-STEP_LO)) begin
            return STEP_W'(STEP_LO);
         end
         return STEP_W'(-longint'(whole));
      end
      if (whole > longint'(STEP_HI)) begin
         return STEP_W'(STEP_HI);
      end
      return STEP_W'(whole);
   endfunction

   task automatic note_cmd(input logic signed [STEP_W-1:0] steps, input logic lim,
                           input logic fin);
      rsp_type cmd;
      cmd.step_count   = steps;
      cmd.led_on       = lim;
      cmd.preset_index = at_index;
      cmd.last         = fin;
      cmds_due.push_back(cmd);
   endtask

   task automatic settle_at_home();
      at_angle = preset_deg[0];
      at_index = '0;
   endtask

   task automatic homing_tick(input logic lim);
      if (!lim) begin
         note_cmd(CRAWL_STEPS, lim, 1'b1);
      end else begin
         note_cmd(STEP_W'(backoff_steps), lim, 1'b0);
         settle_at_home();
         homing = 1'b0;
         note_cmd(STEP_W'(offset_steps), lim, 1'b1);
      end
   endtask

   task automatic run_tick(input req_type item);
      logic             btn;
      logic             lim;
      int               span;
      int               target;
      int               delta;
      logic [IDX_W-1:0] next_at;
      btn = item.button_level;
      lim = item.limit_level;
      if (homing) begin
         if (held_for != HELD_MAX) begin
            held_for = held_for + 1'b1;
         end
         homing_tick(lim);
         return;
      end
      if (btn != button_seen) begin
         button_seen = btn;
         held_for    = '0;
      end else if (held_for != HELD_MAX) begin
         held_for = held_for + 1'b1;
      end
      if (!btn && held_for >= LONG_PRESS_TICKS_DEF && !long_hold) begin
         long_hold = 1'b1;
         settle_at_home();
      end
      if (btn && long_hold) begin
         long_hold = 1'b0;
      end
      if (long_hold && !lim) begin
         note_cmd(CRAWL_STEPS, lim, 1'b1);
         return;
      end
      if (!btn && held_for > DEBOUNCE_TICKS_DEF && !press_taken) begin
         press_taken = 1'b1;
         span = int'(presets_used);
         if (span == 0) begin
            span = 1;
         end
         if (span > MAX_PRESETS_DEF) begin
            span = MAX_PRESETS_DEF;
         end
         next_at = IDX_W'((int'(at_index) + 1) % span);
         if (next_at == '0) begin
            homing = 1'b1;
            homing_tick(lim);
            return;
         end
         target = int'(preset_deg[next_at]);
         delta  = target - int'(at_angle);
         if (delta > int'(HALF_TURN)) begin
            delta = delta - int'(FULL_TURN);
         end
         if (delta < -int'(HALF_TURN)) begin
            delta = delta + int'(FULL_TURN);
         end
         at_angle = preset_deg[next_at];
         at_index = next_at;
         note_cmd(steps_for(delta), lim, 1'b1);
         return;
      end
      if (btn) begin
         press_taken = 1'b0;
      end
      note_cmd('0, lim, 1'b1);
   endtask

   function automatic void match_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         preset_deg[0] = PRESET_ANGLE_0_RST;
         preset_deg[1] = PRESET_ANGLE_1_RST;
         preset_deg[2] = PRESET_ANGLE_2_RST;
         preset_deg[3] = PRESET_ANGLE_3_RST;
         presets_used  = PRESET_COUNT_RST;
         steps_per_deg = STEPS_PER_DEG_RST;
         backoff_steps = RELEASE_STEPS_RST;
         offset_steps  = ZERO_OFFSET_RST;
         homing        = 1'b1;
         button_seen   = 1'b1;
         held_for      = '0;
         long_hold     = 1'b0;
         press_taken   = 1'b0;
         at_index      = '0;
         at_angle      = PRESET_ANGLE_0_RST;
         cmds_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRESET_ANGLE_0: preset_deg[0] = csr_wdata[ANGLE_W-1:0];
               CSR_PRESET_ANGLE_1: preset_deg[1] = csr_wdata[ANGLE_W-1:0];
               CSR_PRESET_ANGLE_2: preset_deg[2] = csr_wdata[ANGLE_W-1:0];
               CSR_PRESET_ANGLE_3: preset_deg[3] = csr_wdata[ANGLE_W-1:0];
               CSR_PRESET_COUNT:   presets_used  = csr_wdata[COUNT_W-1:0];
               CSR_STEPS_PER_DEG:  steps_per_deg = csr_wdata[SPD_W-1:0];
               CSR_RELEASE_STEPS:  backoff_steps = csr_wdata[MOVE_W-1:0];
               CSR_ZERO_OFFSET:    offset_steps  = csr_wdata[MOVE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            run_tick(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (cmds_due.size() == 0) begin
               $display("%0t: unexpected item, steps %0d led %0d index %0d last %0d",
                        $time, rsp_data.step_count, rsp_data.led_on,
                        rsp_data.preset_index, rsp_data.last);
               faults++;
            end else begin
               want = cmds_due.pop_front();
               match_field("step_count", int'(want.step_count), int'(rsp_data.step_count));
               match_field("led_on", int'(want.led_on), int'(rsp_data.led_on));
               match_field("preset_index", int'(want.preset_index),
                           int'(rsp_data.preset_index));
               match_field("last", int'(want.last), int'(rsp_data.last));
            end
         end
      end
      cmds_owed   <= cmds_due.size();
      fault_count <= faults;
   end

endmodule

// ===== bench/testbench.sv =====
// Bench top: drives ticks and register writes into the preset rotator and gives the verdict.
`timescale 1ns / 1ps
module testbench
   import prhc_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASES       = 6;
   localparam int PHASE_TICKS  = 240;
   localparam int SPD_MAX      = (1 << SPD_W) - 1;
   localparam int MOVE_MAX     = (1 << MOVE_W) - 1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int          cmds_owed;
   int          fault_count;
   int          idle_cycles;
   int unsigned burst_left;
   int unsigned ticks_sent;
   int unsigned quiet_left;
   int unsigned stall_left;
   int unsigned run_left;

   preset_rotator_homing_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rotator_checker check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmds_owed   (cmds_owed),
      .fault_count (fault_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (quiet_left != 0) begin
         quiet_left <= quiet_left - 1;
         rsp_ready  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (run_left != 0) begin
         run_left  <= run_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 7))
            0:       quiet_left <= $urandom_range(100, 400);
            1, 2:    stall_left <= $urandom_range(5, 25);
            default: stall_left <= $urandom_range(1, 3);
         endcase
         run_left  <= $urandom_range(0, 12);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_tick(input logic btn, input logic lim);
      int      gap;
      req_type item;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      item.button_level = btn;
      item.limit_level  = lim;
      req_valid <= 1'b1;
      req_data  <= item;
      ticks_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_button(input logic level, input int ticks, input int trip_odds);
      repeat (ticks) send_tick(level, $urandom_range(1, trip_odds) == 1);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value,
                            input int width);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= (CSR_DATA_W'($urandom) << width)
                   | CSR_DATA_W'(value & ((32'd1 << width) - 1));
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic go_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (cmds_owed != 0);
   endtask

   initial begin : stimulus
      int          ang [NUM_PRESETS];
      int unsigned cnt;
      int unsigned spd;
      int unsigned rel;
      int unsigned off;
      int          trip_odds;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // homing after reset, button ignored, release, then the missed edge
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         go_idle();
         for (int k = 0; k < NUM_PRESETS; k++) begin
            ang[k] = int'($urandom_range(0, 2 * int'(HALF_TURN))) - int'(HALF_TURN);
         end
         cnt = $urandom_range(0, (1 << COUNT_W) - 1);
         spd = $urandom_range(0, SPD_MAX);
         rel = $urandom_range(0, MOVE_MAX);
         off = $urandom_range(0, MOVE_MAX);
         case (phase)
            0: begin
               ang = '{int'(HALF_TURN), -int'(HALF_TURN), int'(HALF_TURN), -int'(HALF_TURN)};
               cnt = MAX_PRESETS_DEF;
               spd = SPD_MAX;
               rel = MOVE_MAX;
               off = MOVE_MAX;
            end
            1: begin
               ang[0] = -int'(HALF_TURN);
               cnt    = 0;
               spd    = 0;
               rel    = 0;
               off    = 0;
            end
            2: cnt = (1 << COUNT_W) - 1;
            3: cnt = 1;
            4: cnt = 2;
            default: ;
         endcase
         write_reg(CSR_PRESET_ANGLE_0, ang[0], ANGLE_W);
         write_reg(CSR_PRESET_ANGLE_1, ang[1], ANGLE_W);
         write_reg(CSR_PRESET_ANGLE_2, ang[2], ANGLE_W);
         write_reg(CSR_PRESET_ANGLE_3, ang[3], ANGLE_W);
         write_reg(CSR_PRESET_COUNT, cnt, COUNT_W);
         write_reg(CSR_STEPS_PER_DEG, spd, SPD_W);
         write_reg(CSR_RELEASE_STEPS, rel, MOVE_W);
         write_reg(CSR_ZERO_OFFSET, off, MOVE_W);
         write_reg(CSR_INDEX_W'($urandom_range(CSR_ZERO_OFFSET + 1, (1 << CSR_INDEX_W) - 1)),
                   $urandom, CSR_DATA_W);
         csr_valid <= 1'b0;

         // hold past the long-press limit; the first one runs into counter saturation
         if (phase == 0) begin
            hold_button(1'b0, 4300, 128);
         end else if (phase == 2) begin
            hold_button(1'b0, $urandom_range(3000, 3400), 128);
         end

         ticks_sent = 0;
         while (ticks_sent < PHASE_TICKS) begin
            trip_odds = ($urandom_range(0, 3) == 0) ? 2 : 12;
            case ($urandom_range(0, 9))
               0, 1: begin
                  repeat ($urandom_range(10, 30)) begin
                     send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
                  end
               end
               2: begin
                  hold_button(1'b0, $urandom_range(1, DEBOUNCE_TICKS_DEF), trip_odds);
                  hold_button(1'b1, $urandom_range(1, 10), trip_odds);
               end
               3: hold_button(1'b1, $urandom_range(20, 60), 40);
               default: begin
                  hold_button(1'b1, $urandom_range(1, 8), trip_odds);
                  hold_button(1'b0, $urandom_range(DEBOUNCE_TICKS_DEF - 5,
                                                   DEBOUNCE_TICKS_DEF + 20), trip_odds);
                  hold_button(1'b1, $urandom_range(1, 10), trip_odds);
               end
            endcase
         end
      end

      go_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
